[sv/lmpf_pkg.sv]
// Package with the types, constants and register codes of the local maxima peak finder.
package lmpf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_PEAKS  = 4096;

  localparam int RST_WIDTH     = 1024;
  localparam int RST_HEIGHT    = 1024;
  localparam int RST_MAX_PEAKS = 4096;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 3;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] LUMA_R_COEF = 16'd19595;
  localparam logic [15:0] LUMA_G_COEF = 16'd38470;
  localparam logic [15:0] LUMA_B_COEF = 16'd7471;
  localparam logic [23:0] LUMA_ROUND  = 24'd32768;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_MAX_PEAKS = 3'd1,
    REG_MODE      = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_PEAK = 1'b0,
    KIND_DONE = 1'b1
  } result_kind_t;

  typedef enum logic {
    BK_FIRST  = 1'b0,
    BK_SECOND = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  peak_x;
    logic [9:0]  peak_y;
    logic [7:0]  peak_value;
    logic [12:0] peak_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        peak;
    logic        done;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  value;
    logic [12:0] count;
  } event_t;

endpackage

[sv/lmpf_front.sv]
// Front end: configuration registers, luma, line store, 3x3 window and peak classification.
module lmpf_front import lmpf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_PEAKS  = DEF_MAX_PEAKS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   push,
  output event_t                 push_data,
  input  logic                   full
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int KW = $clog2(MAX_PEAKS + 1);
  localparam int RST_COL_LAST = ((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1;
  localparam int RST_ROW_LAST = ((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT) - 1;
  localparam int RST_LIMIT    = (RST_MAX_PEAKS > MAX_PEAKS) ? MAX_PEAKS : RST_MAX_PEAKS;

  // Configuration, held with the geometry as last indexes and the limit already clamped.
  logic [7:0]    threshold;
  logic          mode8;
  logic [XW-1:0] col_last;
  logic [YW-1:0] row_last;
  logic [KW-1:0] limit;

  logic [10:0]   width_v;
  logic [10:0]   height_v;
  logic [12:0]   peaks_v;
  logic [XW-1:0] col_last_w;
  logic [YW-1:0] row_last_w;
  logic [KW-1:0] limit_w;

  assign width_v  = cfg_data[10:0];
  assign height_v = cfg_data[10:0];
  assign peaks_v  = cfg_data[12:0];

  always_comb begin
    if (width_v == 11'd0) begin
      col_last_w = '0;
    end else if (32'(width_v) > MAX_WIDTH) begin
      col_last_w = XW'(MAX_WIDTH - 1);
    end else begin
      col_last_w = XW'(width_v - 11'd1);
    end
    if (height_v == 11'd0) begin
      row_last_w = '0;
    end else if (32'(height_v) > MAX_HEIGHT) begin
      row_last_w = YW'(MAX_HEIGHT - 1);
    end else begin
      row_last_w = YW'(height_v - 11'd1);
    end
    if (peaks_v == 13'd0) begin
      limit_w = KW'(1);
    end else if (32'(peaks_v) > MAX_PEAKS) begin
      limit_w = KW'(MAX_PEAKS);
    end else begin
      limit_w = KW'(peaks_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      mode8     <= 1'b0;
      col_last  <= XW'(RST_COL_LAST);
      row_last  <= YW'(RST_ROW_LAST);
      limit     <= KW'(RST_LIMIT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[7:0];
        REG_MAX_PEAKS: limit     <= limit_w;
        REG_MODE:      mode8     <= cfg_data[0];
        REG_WIDTH:     col_last  <= col_last_w;
        REG_HEIGHT:    row_last  <= row_last_w;
        default: ;
      endcase
    end
  end

  // The whole front pipeline moves together whenever the queue has room.
  logic run;
  logic accept;

  assign run         = !full;
  assign pixel_ready = run;
  assign accept      = pixel_valid && run;

  // Stage 0: raster position and luma products.
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [XW-1:0] col_next;
  logic [YW-1:0] row_next;
  logic          restart0;
  logic [XW-1:0] c0;
  logic [YW-1:0] r0;
  logic          end_row0;
  logic          end_frame0;

  always_comb begin
    restart0   = pixel.frame_start || (col > col_last) || (row > row_last);
    c0         = restart0 ? '0 : col;
    r0         = restart0 ? '0 : row;
    end_row0   = (c0 == col_last);
    end_frame0 = end_row0 && (r0 == row_last);
    if (end_frame0) begin
      col_next = '0;
      row_next = '0;
    end else if (end_row0) begin
      col_next = '0;
      row_next = r0 + YW'(1);
    end else begin
      col_next = c0 + XW'(1);
      row_next = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  logic          s1_valid;
  logic [XW-1:0] s1_c;
  logic [YW-1:0] s1_r;
  logic          s1_restart;
  logic          s1_end_frame;
  logic          s1_test;
  logic [23:0]   s1_prod_r;
  logic [23:0]   s1_prod_g;
  logic [23:0]   s1_prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (run) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s1_c         <= c0;
      s1_r         <= r0;
      s1_restart   <= restart0;
      s1_end_frame <= end_frame0;
      s1_test      <= (c0 >= XW'(2)) && (r0 >= YW'(2));
      s1_prod_r    <= LUMA_R_COEF * pixel.red;
      s1_prod_g    <= LUMA_G_COEF * pixel.green;
      s1_prod_b    <= LUMA_B_COEF * pixel.blue;
    end
  end

  // Line store: each entry holds the two previous rows, older in the upper byte.
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] line_q;
  logic        fwd_hit;
  logic [15:0] fwd_data;
  logic [15:0] line_rd;
  logic [23:0] luma_sum;
  logic [7:0]  luma;
  logic [15:0] line_wr;

  assign luma_sum = s1_prod_r + s1_prod_g + s1_prod_b + LUMA_ROUND;
  assign luma     = luma_sum[23:16];
  assign line_rd  = fwd_hit ? fwd_data : line_q;
  assign line_wr  = {line_rd[7:0], luma};

  always_ff @(posedge clk) begin
    if (run) begin
      line_q <= line_mem[c0];
      if (s1_valid) begin
        line_mem[s1_c] <= line_wr;
      end
    end
  end

  // A read that meets the write of the same column in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (run) begin
      fwd_hit  <= s1_valid && (s1_c == c0);
      fwd_data <= line_wr;
    end
  end

  // Stage 1 to 2: the window, cells numbered row by row with the newest column on the right.
  logic [7:0]    win [9];
  logic          s2_valid;
  logic [XW-1:0] s2_c;
  logic [YW-1:0] s2_r;
  logic          s2_restart;
  logic          s2_end_frame;
  logic          s2_test;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (run) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= line_rd[15:8];
        win[5] <= line_rd[7:0];
        win[8] <= luma;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s2_c         <= s1_c;
      s2_r         <= s1_r;
      s2_restart   <= s1_restart;
      s2_end_frame <= s1_end_frame;
      s2_test      <= s1_test;
    end
  end

  // Stage 2: peak test and per-frame count.
  logic [KW-1:0] found;
  logic          stopped;
  logic [KW-1:0] cnt_base;
  logic          stop_base;
  logic          above4;
  logic          above8;
  logic          is_peak;
  logic [KW-1:0] cnt_new;

  always_comb begin
    cnt_base  = s2_restart ? '0 : found;
    stop_base = s2_restart ? 1'b0 : stopped;
    above4    = (win[4] > threshold) && (win[4] > win[5]) && (win[4] > win[3]) &&
                (win[4] > win[1]) && (win[4] > win[7]);
    above8    = (win[4] > win[0]) && (win[4] > win[2]) && (win[4] > win[6]) &&
                (win[4] > win[8]);
    is_peak   = s2_test && !stop_base && above4 && (!mode8 || above8);
    cnt_new   = cnt_base + KW'(is_peak);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= '0;
      stopped <= 1'b0;
    end else if (run && s2_valid) begin
      if (s2_end_frame) begin
        found   <= '0;
        stopped <= 1'b0;
      end else begin
        found   <= cnt_new;
        stopped <= stop_base || (is_peak && (cnt_new >= limit));
      end
    end
  end

  assign push            = run && s2_valid && (is_peak || s2_end_frame);
  assign push_data.peak  = is_peak;
  assign push_data.done  = s2_end_frame;
  assign push_data.x     = 10'(s2_c - XW'(1));
  assign push_data.y     = 10'(s2_r - YW'(1));
  assign push_data.value = win[4];
  assign push_data.count = 13'(cnt_new);

endmodule

[sv/lmpf_queue.sv]
// Short event queue between the front end and the result stage.
module lmpf_queue import lmpf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_data,
  output logic   full,
  input  logic   pop,
  output event_t head,
  output logic   empty
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  event_t        slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;

  assign full  = (count == (QW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/lmpf_back.sv]
// Result stage: turns queued events into peak and frame-done results in an output register.
module lmpf_back import lmpf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  event_t  head,
  input  logic    empty,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  bk_state_t state;
  bk_state_t state_next;
  logic      load;
  result_t   result_next;
  result_t   peak_rec;
  result_t   done_rec;

  assign load = !result_valid || result_ready;

  always_comb begin
    peak_rec.kind       = KIND_PEAK;
    peak_rec.peak_x     = head.x;
    peak_rec.peak_y     = head.y;
    peak_rec.peak_value = head.value;
    peak_rec.peak_count = '0;
    peak_rec.last       = !head.done;
    done_rec.kind       = KIND_DONE;
    done_rec.peak_x     = '0;
    done_rec.peak_y     = '0;
    done_rec.peak_value = '0;
    done_rec.peak_count = head.count;
    done_rec.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_FIRST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    result_next = done_rec;
    if (load && !empty) begin
      unique case (state)
        BK_FIRST: begin
          if (head.peak) begin
            result_next = peak_rec;
            if (head.done) begin
              state_next = BK_SECOND;
            end else begin
              pop = 1'b1;
            end
          end else begin
            pop = 1'b1;
          end
        end
        BK_SECOND: begin
          pop        = 1'b1;
          state_next = BK_FIRST;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      result <= result_next;
    end
  end

endmodule

[sv/local_maxima_peak_finder.sv]
// Top level of the local maxima peak finder.
// Pixels of an accumulator image arrive in raster order, one transfer per clock at full rate.
// Each is reduced to 8-bit luma and passed through a line store of the two previous rows and
// a 3x3 window; an inner cell that exceeds the threshold and all of its four or eight
// neighbors gives a peak record, up to the peak limit, and the last pixel of a frame gives a
// frame-done record with the peak count. Events go from the stage 2 registers through the
// queue to the output register. The front end and the line store take one pixel per cycle
// while the queue has room; a pixel with both a peak and a frame-done record fills the output
// register twice, which the four-entry queue absorbs. The input stalls only while it is full.
module local_maxima_peak_finder import lmpf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_PEAKS  = DEF_MAX_PEAKS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  logic   push;
  event_t push_data;
  logic   full;
  logic   pop;
  event_t head;
  logic   empty;

  lmpf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_PEAKS (MAX_PEAKS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  lmpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  lmpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

[sv/lmpf_checker.sv]
// Port-level checker for the local maxima peak finder and its bind to the top level.
module lmpf_checker import lmpf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pixel_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> pixel_ready)
    else $error("pixel input not ready after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed before its transfer");

  a_done_follows_peak: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && (result.kind == KIND_PEAK) && !result.last
    |=> result_valid && (result.kind == KIND_DONE))
    else $error("peak record without last flag not followed by frame-done record");

endmodule

bind local_maxima_peak_finder lmpf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_ready (pixel_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);
